[hdl/kpd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpd_pkg
// Shared types and constants for the key press detector and its event queue.
// ----------------------------------------------------------------------------
package kpd_pkg;

   localparam int NUM_KEYS_DEFAULT    = 20;
   localparam int QUEUE_DEPTH_DEFAULT = 32;
   localparam int SAMPLE_BITS_DEFAULT = 12;

   // depth of the command queue between front and back
   localparam int CMD_FIFO_DEPTH = 4;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 12;

   localparam logic [7:0]  STATUS_FLAG    = 8'h80;
   localparam logic [7:0]  VELOCITY_ON    = 8'h7f;
   localparam logic [7:0]  VELOCITY_OFF   = 8'h01;
   localparam logic [11:0] ON_OFFSET_RST  = 12'd200;
   localparam logic [11:0] OFF_THRESH_RST = 12'd100;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_NOTE_OFFSET   = 2'd0,
      CSR_ON_OFFSET     = 2'd1,
      CSR_OFF_THRESHOLD = 2'd2
   } csr_index_type;

   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_POP    = 1'b1
   } cmd_type;

   typedef struct packed {
      logic        cmd;
      logic [4:0]  key_index;
      logic [11:0] sample;
   } req_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic       queue_empty;
      logic       event_made;
      logic       event_dropped;
      logic       key_is_on;
   } rsp_type;

   // classified item handed from the front to the back
   typedef struct packed {
      logic       is_pop;
      logic       event_made;
      logic       key_is_on;
      logic [7:0] status;
   } cmd_entry_type;

endpackage

[hdl/kpd_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module kpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/kpd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpd_front
// Configuration registers and per-key peak / on state; classifies each item.
// ----------------------------------------------------------------------------
module kpd_front #(
   parameter int NUM_KEYS    = kpd_pkg::NUM_KEYS_DEFAULT,
   parameter int SAMPLE_BITS = kpd_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [kpd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [kpd_pkg::CSR_DATA_BITS-1:0]   csr_data,
   input  logic                                accept,
   input  kpd_pkg::req_type                    req_data,
   output kpd_pkg::cmd_entry_type              entry
);

   localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int CMP_W = ((SAMPLE_BITS > 12) ? SAMPLE_BITS : 12) + 2;

   logic [7:0]              note_offset_ff;
   logic [11:0]             on_offset_ff;
   logic [11:0]             off_thresh_ff;
   logic [SAMPLE_BITS-1:0]  peak_ff [NUM_KEYS];
   logic [NUM_KEYS-1:0]     key_on_ff;

   logic                    key_in_range;
   logic [KEY_W-1:0]        idx;
   logic [SAMPLE_BITS-1:0]  smp;
   logic [SAMPLE_BITS-1:0]  cur_peak;
   logic [SAMPLE_BITS-1:0]  peak_in;
   logic                    cur_on;
   logic                    on_in;
   logic signed [CMP_W-1:0] s_x;
   logic signed [CMP_W-1:0] pk_x;
   logic signed [CMP_W-1:0] on_thr;
   logic signed [CMP_W-1:0] off_thr;
   logic                    change;
   logic                    update;

   always_ff @(posedge clock) begin
      if (reset) begin
         note_offset_ff <= '0;
         on_offset_ff   <= kpd_pkg::ON_OFFSET_RST;
         off_thresh_ff  <= kpd_pkg::OFF_THRESH_RST;
      end else if (csr_valid) begin
         case (csr_index)
            kpd_pkg::CSR_NOTE_OFFSET:   note_offset_ff <= csr_data[7:0];
            kpd_pkg::CSR_ON_OFFSET:     on_offset_ff   <= csr_data;
            kpd_pkg::CSR_OFF_THRESHOLD: off_thresh_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign key_in_range = int'(req_data.key_index) < NUM_KEYS;
   assign idx          = KEY_W'(req_data.key_index);
   assign smp          = SAMPLE_BITS'(req_data.sample);
   assign cur_peak     = key_in_range ? peak_ff[idx] : '0;
   assign cur_on       = key_in_range ? key_on_ff[idx] : 1'b0;
   assign peak_in      = (smp > cur_peak) ? smp : cur_peak;

   // thresholds may go below zero, hence the signed compare
   assign s_x     = CMP_W'(smp);
   assign pk_x    = CMP_W'(peak_in);
   assign on_thr  = pk_x - CMP_W'(on_offset_ff);
   assign off_thr = pk_x - CMP_W'(off_thresh_ff);

   assign change = cur_on ? (s_x > off_thr) : (s_x < on_thr);
   assign on_in  = cur_on ^ change;
   assign update = accept && (req_data.cmd == kpd_pkg::CMD_SAMPLE) && key_in_range;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_on_ff <= '0;
         for (int k = 0; k < NUM_KEYS; k++) begin
            peak_ff[k] <= '0;
         end
      end else if (update) begin
         peak_ff[idx]   <= peak_in;
         key_on_ff[idx] <= on_in;
      end
   end

   always_comb begin
      entry.is_pop     = (req_data.cmd == kpd_pkg::CMD_POP);
      entry.event_made = !entry.is_pop && key_in_range && change;
      entry.key_is_on  = !entry.is_pop && key_in_range && on_in;
      entry.status     = (8'(req_data.key_index) + note_offset_ff) | kpd_pkg::STATUS_FLAG;
   end

endmodule

[hdl/kpd_cmd_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpd_cmd_fifo
// Short flop queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module kpd_cmd_fifo #(
   parameter int DEPTH = kpd_pkg::CMD_FIFO_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  kpd_pkg::cmd_entry_type push_data,
   output logic                   full,
   input  logic                   pop,
   output logic                   head_valid,
   output kpd_pkg::cmd_entry_type head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   kpd_pkg::cmd_entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hdl/kpd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpd_back
// Event byte ring: queues event pairs, serves pops, drives the result register.
// ----------------------------------------------------------------------------
module kpd_back #(
   parameter int QUEUE_DEPTH = kpd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  kpd_pkg::cmd_entry_type head_data,
   output logic                   head_take,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output kpd_pkg::rsp_type       rsp_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1) + 1;

   logic [PTR_W-1:0] wr_slot_ff, wr_slot_in;
   logic [PTR_W-1:0] rd_slot_ff, rd_slot_in;
   logic             pending_ff;
   logic [7:0]       pend_byte_ff;

   logic             s1_valid_ff;
   logic             s1_rd_ff;
   kpd_pkg::rsp_type s1_ff;
   logic             out_valid_ff;
   kpd_pkg::rsp_type out_ff;

   logic [CNT_W-1:0] count;
   logic             room;
   logic             ring_empty;
   logic             need_write;
   logic             out_free;
   logic             s1_free;
   logic             move_out;

   logic             ram_we;
   logic [PTR_W-1:0] ram_waddr;
   logic [7:0]       ram_wdata;
   logic             ram_re;
   logic [7:0]       ram_rdata;

   assign count = (wr_slot_ff >= rd_slot_ff)
                ? CNT_W'(wr_slot_ff) - CNT_W'(rd_slot_ff)
                : CNT_W'(QUEUE_DEPTH) - CNT_W'(rd_slot_ff) + CNT_W'(wr_slot_ff);
   // ring keeps one slot unused, an event needs two
   assign room       = (count + CNT_W'(3)) <= CNT_W'(QUEUE_DEPTH);
   assign ring_empty = (rd_slot_ff == wr_slot_ff);
   assign need_write = !head_data.is_pop && head_data.event_made && room;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign move_out  = s1_valid_ff && out_free;
   assign s1_free   = !s1_valid_ff || out_free;
   // second byte of a pair still owns the write port
   assign head_take = head_valid && s1_free && !(pending_ff && need_write);

   assign ram_re = head_take && head_data.is_pop && !ring_empty;

   always_comb begin
      ram_we     = 1'b0;
      ram_waddr  = wr_slot_ff;
      ram_wdata  = pend_byte_ff;
      wr_slot_in = wr_slot_ff;
      rd_slot_in = rd_slot_ff;
      if (pending_ff) begin
         ram_we = 1'b1;
      end else if (head_take && need_write) begin
         ram_we    = 1'b1;
         ram_wdata = head_data.status;
      end
      if (ram_we) begin
         wr_slot_in = (wr_slot_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_slot_ff + 1'b1;
      end
      if (ram_re) begin
         rd_slot_in = (rd_slot_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_slot_ff + 1'b1;
      end
   end

   kpd_ram #(
      .WIDTH (8),
      .DEPTH (QUEUE_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (rd_slot_ff),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_slot_ff   <= '0;
         rd_slot_ff   <= '0;
         pending_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         wr_slot_ff <= wr_slot_in;
         rd_slot_ff <= rd_slot_in;
         if (pending_ff) begin
            pending_ff <= 1'b0;
         end else if (head_take && need_write) begin
            pending_ff <= 1'b1;
         end
         if (head_take) begin
            s1_valid_ff <= 1'b1;
         end else if (move_out) begin
            s1_valid_ff <= 1'b0;
         end
         if (move_out) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (head_take && need_write) begin
         pend_byte_ff <= head_data.key_is_on ? kpd_pkg::VELOCITY_ON : kpd_pkg::VELOCITY_OFF;
      end
      if (head_take) begin
         s1_rd_ff            <= ram_re;
         s1_ff.read_byte     <= '0;
         s1_ff.queue_empty   <= head_data.is_pop && ring_empty;
         s1_ff.event_made    <= head_data.event_made;
         s1_ff.event_dropped <= head_data.event_made && !room;
         s1_ff.key_is_on     <= head_data.key_is_on;
      end
      if (move_out) begin
         out_ff.read_byte     <= s1_rd_ff ? ram_rdata : s1_ff.read_byte;
         out_ff.queue_empty   <= s1_ff.queue_empty;
         out_ff.event_made    <= s1_ff.event_made;
         out_ff.event_dropped <= s1_ff.event_dropped;
         out_ff.key_is_on     <= s1_ff.key_is_on;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

[hdl/key_press_detector_with_event_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_press_detector_with_event_queue
// Per-key press/release detection with a byte ring of note events.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one item per accepted cycle (req_valid && !req_stall); cmd 0
//            carries a key sample, cmd 1 pops one byte from the event ring.
//   rsp_*  : exactly one result item per request item, in order, taken when
//            rsp_valid && !rsp_stall.
//   csr_*  : register writes, always ready; write only while the block is idle.
// rsp_valid rises once a request has passed the command queue, the back stage
// and the result register. Throughput is one item per cycle while rsp_stall
// is low; an event that is queued writes its status and velocity bytes through
// the ring write port one after the other, so a second queued event right
// behind it waits in the command queue.
// Reset clears all peaks, on flags, ring pointers and pipeline valids and loads
// the register defaults. The ring contents are not cleared; no entry is read
// before it is written.
// A stalled receiver holds the result register; the back and the command queue
// fill behind it and req_stall rises once the command queue is full.
// ----------------------------------------------------------------------------
module key_press_detector_with_event_queue #(
   parameter int NUM_KEYS    = kpd_pkg::NUM_KEYS_DEFAULT,
   parameter int QUEUE_DEPTH = kpd_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int SAMPLE_BITS = kpd_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  kpd_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output kpd_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [kpd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [kpd_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   logic                   fifo_full;
   logic                   accept;
   kpd_pkg::cmd_entry_type entry;
   logic                   head_valid;
   kpd_pkg::cmd_entry_type head_data;
   logic                   head_take;

   assign csr_ready = 1'b1;
   assign req_stall = fifo_full;
   assign accept    = req_valid && !fifo_full;

   kpd_front #(
      .NUM_KEYS    (NUM_KEYS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .accept    (accept),
      .req_data  (req_data),
      .entry     (entry)
   );

   kpd_cmd_fifo #(
      .DEPTH (kpd_pkg::CMD_FIFO_DEPTH)
   ) u_cmd_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_data  (entry),
      .full       (fifo_full),
      .pop        (head_take),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   kpd_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .head_take  (head_take),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
